// ===== rtl/brl_pkg.sv =====
// shared types and constants of the byte range lock table
`default_nettype none

package brl_pkg;

  localparam int unsigned OffW = 48;
  localparam int unsigned LenW = 49;
  localparam int unsigned OwnW = 16;

  localparam logic [OffW-1:0] OFF_MASK = {OffW{1'b1}};

  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_OVERLAP = 3'd1;
  localparam logic [2:0] MODE_COVERED = 3'd2;
  localparam logic [2:0] MODE_FOREIGN = 3'd3;
  localparam logic [2:0] MODE_FIND    = 3'd4;
  localparam logic [2:0] MODE_DEL_OWN = 3'd5;
  localparam logic [2:0] MODE_DEL_ST  = 3'd6;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CONFLICT = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  typedef struct packed {
    logic [2:0]      mode;
    logic [OffW-1:0] range_offset;
    logic [LenW-1:0] range_length;
    logic [OwnW-1:0] owner_id;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            answer;
    logic [OffW-1:0] sect_offset;
    logic [LenW-1:0] sect_length;
    logic [OwnW-1:0] sect_owner;
    logic            last;
  } resp_t;

  typedef struct packed {
    logic [OffW-1:0] start;
    logic [OffW-1:0] last_byte;
    logic [LenW-1:0] len;
    logic [OwnW-1:0] owner;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t entry;
  } tbl_cmd_t;

  typedef struct packed {
    logic            ce_lt_start;
    logic            cs_gt_end;
    logic            cs_lt_start;
    logic            cs_eq_start;
    logic            ce_gt_end;
    logic            own_eq;
    logic [OffW-1:0] next_cs;
    logic [LenW-1:0] mid_len;
    logic [LenW-1:0] fin_len;
  } cmp_t;

endpackage

`default_nettype wire

// ===== rtl/brl_table.sv =====
// sorted entry store with shifting insert and remove
`default_nettype none

module brl_table #(
  parameter int unsigned N  = 16,
  parameter int unsigned IW = 4,
  parameter int unsigned CW = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IW-1:0]    rd_idx_i,
  output brl_pkg::entry_t       rd_entry_o,
  input  wire logic [IW-1:0]    wr_idx_i,
  input  brl_pkg::tbl_cmd_t     cmd_i,
  output logic [CW-1:0]         count_o
);
  import brl_pkg::*;

  entry_t        ent_q [N];
  logic [CW-1:0] count_q;

  assign rd_entry_o = ent_q[rd_idx_i];
  assign count_o    = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.ins) begin
      count_q <= count_q + CW'(1);
    end else if (cmd_i.rem) begin
      count_q <= count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins) begin
      for (int j = N - 1; j > 0; j--) begin
        if (IW'(j) > wr_idx_i) begin
          ent_q[j] <= ent_q[j-1];
        end
      end
      ent_q[wr_idx_i] <= cmd_i.entry;
    end else if (cmd_i.rem) begin
      for (int j = 0; j < N - 1; j++) begin
        if (IW'(j) >= wr_idx_i) begin
          ent_q[j] <= ent_q[j+1];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/brl_cmp.sv =====
// shared compare unit: current window against one table entry
`default_nettype none

module brl_cmp (
  input  wire logic [brl_pkg::OffW-1:0] cs_i,
  input  wire logic [brl_pkg::OffW-1:0] ce_i,
  input  wire logic [brl_pkg::OwnW-1:0] own_i,
  input  brl_pkg::entry_t               entry_i,
  output brl_pkg::cmp_t                 cmp_o
);
  import brl_pkg::*;

  always_comb begin
    cmp_o.ce_lt_start = ce_i < entry_i.start;
    cmp_o.cs_gt_end   = cs_i > entry_i.last_byte;
    cmp_o.cs_lt_start = cs_i < entry_i.start;
    cmp_o.cs_eq_start = cs_i == entry_i.start;
    cmp_o.ce_gt_end   = ce_i > entry_i.last_byte;
    cmp_o.own_eq      = own_i == entry_i.owner;
    cmp_o.next_cs     = entry_i.last_byte + OffW'(1);
    cmp_o.mid_len     = {1'b0, entry_i.start} - {1'b0, cs_i};
    cmp_o.fin_len     = {1'b0, ce_i} - {1'b0, cs_i} + LenW'(1);
  end

endmodule

`default_nettype wire

// ===== rtl/byte_range_lock_table.sv =====
// byte range lock table: sequencer, output register and unit hookup
// Requests enter on in_valid_i/in_req_i; in_stall_o is high while a request
// is at work, so one request is handled at a time. Results leave on
// out_valid_o/out_resp_o and are held while out_stall_i is high; the
// table walk waits whenever the output register is full and stalled.
// After a transfer in, a prepare state computes the range end, then the shared
// compare unit visits one table entry per cycle while the output is not stalled.
// An add walks the table once to check conflicts and count pieces, and on
// success walks it again inserting one piece per visited gap and one for any tail.
// An add emits one result per inserted piece (last set on the final one), or
// one result if it inserts nothing; every other request emits exactly one result.
// Reset empties the table; entry contents are not cleared, only the count.
`default_nettype none

module byte_range_lock_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  brl_pkg::req_t in_req_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output brl_pkg::resp_t out_resp_o
);
  import brl_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned NW = $clog2(TABLE_ENTRIES + 3);
  localparam int unsigned SW = NW + 1;
  localparam logic [NW-1:0] NP_SAT = NW'(TABLE_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0]      state_q, state_d;
  req_t            req_q, req_d;
  logic [OffW-1:0] cs_q, cs_d, ce_q, ce_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [NW-1:0]   np_q, np_d, ins_q, ins_d, np_tot;
  logic            hit_q, hit_d, have_q, have_d, pass2_q, pass2_d;
  logic            out_valid_q, emit, out_free, at_end;
  resp_t           resp_q, resp_d;
  entry_t          rd_entry;
  tbl_cmd_t        tbl_cmd;
  logic [IW-1:0]   wr_idx;
  logic [CW-1:0]   count;
  cmp_t            cmp;
  logic [LenW-1:0] lm1;
  logic [LenW:0]   end_sum;

  brl_table #(.N(TABLE_ENTRIES), .IW(IW), .CW(CW)) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx_q[IW-1:0]),
    .rd_entry_o (rd_entry),
    .wr_idx_i   (wr_idx),
    .cmd_i      (tbl_cmd),
    .count_o    (count)
  );

  brl_cmp u_cmp (
    .cs_i    (cs_q),
    .ce_i    (ce_q),
    .own_i   (req_q.owner_id),
    .entry_i (rd_entry),
    .cmp_o   (cmp)
  );

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_resp_o  = resp_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign at_end      = idx_q == count;
  assign np_tot      = np_q + NW'(have_q);

  // zero length counts as one byte, range clipped at the top of the space
  assign lm1     = (req_q.range_length == '0) ? '0 : req_q.range_length - LenW'(1);
  assign end_sum = {2'b0, req_q.range_offset} + {1'b0, lm1};

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    cs_d    = cs_q;
    ce_d    = ce_q;
    idx_d   = idx_q;
    np_d    = np_q;
    ins_d   = ins_q;
    hit_d   = hit_q;
    have_d  = have_q;
    pass2_d = pass2_q;
    emit    = 1'b0;
    resp_d  = '0;
    resp_d.last = 1'b1;
    tbl_cmd = '0;
    wr_idx  = idx_q[IW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cs_d    = req_q.range_offset;
        ce_d    = (end_sum > {2'b0, OFF_MASK}) ? OFF_MASK : end_sum[OffW-1:0];
        idx_d   = '0;
        np_d    = '0;
        ins_d   = '0;
        hit_d   = 1'b0;
        have_d  = 1'b1;
        pass2_d = 1'b0;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (out_free) begin
          unique case (req_q.mode)
            MODE_ADD: begin
              if (at_end || !have_q || cmp.ce_lt_start) begin
                state_d = ST_IDLE;
                if (!pass2_q) begin
                  if (np_tot == '0) begin
                    emit = 1'b1;
                  end else if (SW'(count) + SW'(np_tot) > SW'(TABLE_ENTRIES)) begin
                    emit = 1'b1;
                    resp_d.status = STATUS_FULL;
                  end else begin
                    np_d    = np_tot;
                    pass2_d = 1'b1;
                    cs_d    = req_q.range_offset;
                    idx_d   = '0;
                    have_d  = 1'b1;
                    state_d = ST_WALK;
                  end
                end else if (have_q) begin
                  tbl_cmd.ins             = 1'b1;
                  tbl_cmd.entry.start     = cs_q;
                  tbl_cmd.entry.last_byte = ce_q;
                  tbl_cmd.entry.len       = cmp.fin_len;
                  tbl_cmd.entry.owner     = req_q.owner_id;
                  emit               = 1'b1;
                  resp_d.sect_offset = cs_q;
                  resp_d.sect_length = cmp.fin_len;
                  resp_d.sect_owner  = req_q.owner_id;
                end
              end else if (cmp.cs_gt_end) begin
                idx_d = idx_q + CW'(1);
              end else if (!cmp.own_eq) begin
                emit          = 1'b1;
                resp_d.status = STATUS_CONFLICT;
                state_d       = ST_IDLE;
              end else if (cmp.cs_lt_start && pass2_q) begin
                // gap before this entry: insert the piece, then revisit entry
                tbl_cmd.ins             = 1'b1;
                tbl_cmd.entry.start     = cs_q;
                tbl_cmd.entry.last_byte = rd_entry.start - OffW'(1);
                tbl_cmd.entry.len       = cmp.mid_len;
                tbl_cmd.entry.owner     = req_q.owner_id;
                emit               = 1'b1;
                resp_d.sect_offset = cs_q;
                resp_d.sect_length = cmp.mid_len;
                resp_d.sect_owner  = req_q.owner_id;
                resp_d.last        = (ins_q + NW'(1)) == np_q;
                ins_d = ins_q + NW'(1);
                cs_d  = rd_entry.start;
                idx_d = idx_q + CW'(1);
              end else begin
                if (cmp.cs_lt_start && np_q != NP_SAT) begin
                  np_d = np_q + NW'(1);
                end
                if (cmp.ce_gt_end) begin
                  cs_d  = cmp.next_cs;
                  idx_d = idx_q + CW'(1);
                end else begin
                  have_d = 1'b0;
                end
              end
            end
            MODE_OVERLAP: begin
              if (at_end) begin
                emit          = 1'b1;
                resp_d.answer = hit_q;
                state_d       = ST_IDLE;
              end else begin
                if (!cmp.cs_gt_end && !cmp.ce_lt_start && !cmp.own_eq) begin
                  hit_d = 1'b1;
                end
                idx_d = idx_q + CW'(1);
              end
            end
            MODE_COVERED: begin
              if (at_end || cmp.ce_lt_start) begin
                emit    = 1'b1;
                state_d = ST_IDLE;
              end else if (cmp.cs_gt_end) begin
                idx_d = idx_q + CW'(1);
              end else if (cmp.cs_lt_start) begin
                emit    = 1'b1;
                state_d = ST_IDLE;
              end else if (cmp.ce_gt_end) begin
                cs_d  = cmp.next_cs;
                idx_d = idx_q + CW'(1);
              end else begin
                emit          = 1'b1;
                resp_d.answer = 1'b1;
                state_d       = ST_IDLE;
              end
            end
            MODE_FOREIGN: begin
              if (at_end) begin
                emit          = 1'b1;
                resp_d.answer = hit_q;
                state_d       = ST_IDLE;
              end else begin
                if (!cmp.own_eq) begin
                  hit_d = 1'b1;
                end
                idx_d = idx_q + CW'(1);
              end
            end
            MODE_FIND: begin
              if (at_end) begin
                emit    = 1'b1;
                state_d = ST_IDLE;
              end else if (!cmp.cs_lt_start && !cmp.cs_gt_end) begin
                emit               = 1'b1;
                resp_d.answer      = 1'b1;
                resp_d.sect_offset = rd_entry.start;
                resp_d.sect_length = rd_entry.len;
                resp_d.sect_owner  = rd_entry.owner;
                state_d            = ST_IDLE;
              end else begin
                idx_d = idx_q + CW'(1);
              end
            end
            MODE_DEL_OWN: begin
              if (at_end) begin
                emit    = 1'b1;
                state_d = ST_IDLE;
              end else if (cmp.own_eq) begin
                tbl_cmd.rem = 1'b1;
              end else begin
                idx_d = idx_q + CW'(1);
              end
            end
            MODE_DEL_ST: begin
              if (at_end) begin
                emit    = 1'b1;
                state_d = ST_IDLE;
              end else if (cmp.cs_eq_start) begin
                tbl_cmd.rem = 1'b1;
                emit        = 1'b1;
                state_d     = ST_IDLE;
              end else begin
                idx_d = idx_q + CW'(1);
              end
            end
            default: begin
              emit    = 1'b1;
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    cs_q    <= cs_d;
    ce_q    <= ce_d;
    idx_q   <= idx_d;
    np_q    <= np_d;
    ins_q   <= ins_d;
    hit_q   <= hit_d;
    have_q  <= have_d;
    pass2_q <= pass2_d;
    if (emit) begin
      resp_q <= resp_d;
    end
  end

endmodule

`default_nettype wire
